// ===== hw/rtl/hpq_pkg.sv =====
`timescale 1ns / 1ps

package hpq_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int TAG_WIDTH_DEF = 16;

	// fixed widths of the channel fields
	localparam int PRIO_W   = 32;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_UP_CHK  = 9'b000000010,
		S_UP_CMP  = 9'b000000100,
		S_RM_ROOT = 9'b000001000,
		S_RM_LAST = 9'b000010000,
		S_DN_CHK  = 9'b000100000,
		S_DN_L    = 9'b001000000,
		S_DN_R    = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

endpackage

// ===== hw/rtl/hpq_in_if.sv =====
`timescale 1ns / 1ps

interface hpq_in_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [hpq_pkg::PRIO_W-1:0] priority_req;
	logic [hpq_pkg::TAG_W-1:0]  tag;

	modport source (output valid, output opcode, output priority_req, output tag, input ready);
	modport sink   (input valid, input opcode, input priority_req, input tag, output ready);
endinterface

// ===== hw/rtl/hpq_out_if.sv =====
`timescale 1ns / 1ps

interface hpq_out_if;
	logic                         valid;
	logic                         ready;
	logic [hpq_pkg::STATUS_W-1:0] status;
	logic [hpq_pkg::PRIO_W-1:0]   out_priority;
	logic [hpq_pkg::TAG_W-1:0]    out_tag;
	logic [hpq_pkg::OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output out_priority, output out_tag,
		output occupancy, input ready);
	modport sink   (input valid, input status, input out_priority, input out_tag,
		input occupancy, output ready);
endinterface

// ===== hw/rtl/hpq_rank.sv =====
`timescale 1ns / 1ps

// Shared rank comparator: lower is set when key a ranks strictly below key b.
module hpq_rank #(
	parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF
) (
	input  logic                 mode,
	input  logic [KEY_WIDTH-1:0] a,
	input  logic [KEY_WIDTH-1:0] b,
	output logic                 lower
);
	// mode 0: largest first, so a smaller key ranks lower
	assign lower = mode ? (a > b) : (a < b);
endmodule

// ===== hw/rtl/binary_heap_priority_queue.sv =====
`timescale 1ns / 1ps

// Binary-heap priority queue.
// req channel (valid/ready): opcode 0 inserts {priority_req, tag}, opcode 1 removes
// the top entry. rsp channel (valid/ready): one transaction per request carrying
// status (ok, full, empty), the removed entry (zero otherwise) and the occupancy.
// cfg_we/cfg_wdata writes order_mode: 0 largest first, 1 smallest first; write it
// only while the queue is idle.
// One request is worked at a time; req.ready is high only when the sequencer is
// idle. The heap sits in a single-port-write, registered-read memory and one
// comparator is shared over the sift. Insert climbs one level per step: it reads the
// parent, compares, and writes either the parent or the carried entry. Remove reads
// the root and the last entry, then per level reads the left and, if present, the
// right child, compares and writes; refused requests go straight to the result.
// The result sits in an output register, so a stalled rsp does not block the
// next request; only a second result waits until the first is taken.
// Reset clears the occupancy, order_mode and the handshakes; heap memory
// content is not cleared and needs no clearing pass.
module binary_heap_priority_queue #(
	parameter int CAPACITY  = hpq_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF,
	parameter int TAG_WIDTH = hpq_pkg::TAG_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	hpq_in_if.sink    req,
	hpq_out_if.source rsp
);
	import hpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = CW + 1;
	localparam int TS = (TAG_WIDTH > 0) ? TAG_WIDTH : 1;
	localparam int EW = KEY_WIDTH + TS;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic          mode_q;
	logic [AW-1:0] idx_q;
	logic [KEY_WIDTH-1:0] x_key_q, best_key_q;
	logic [TS-1:0]        x_tag_q, best_tag_q;
	logic                 best_child_q;
	logic [KEY_WIDTH-1:0] res_key_q;
	logic [TS-1:0]        res_tag_q;
	logic [STATUS_W-1:0]  res_status_q;

	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic [TS-1:0]        out_tag_q;
	logic [CW-1:0]        out_count_q;

	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rd_data_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data;

	logic [KEY_WIDTH-1:0] rd_key;
	logic [TS-1:0]        rd_tag;
	logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
	logic                 cmp_lower;

	logic [KEY_WIDTH+PRIO_W-1:0] key_wide;
	logic [TS+TAG_W-1:0]         tag_wide;
	logic [KEY_WIDTH-1:0]        key_in;
	logic [TS-1:0]               tag_in;

	logic [AW-1:0] parent;
	logic [LW-1:0] left_w, right_w, count_w;
	logic          accept;
	logic          out_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign key_wide = {{KEY_WIDTH{1'b0}}, req.priority_req};
	assign tag_wide = {{TS{1'b0}}, req.tag};
	assign key_in   = key_wide[KEY_WIDTH-1:0];
	assign tag_in   = (TAG_WIDTH > 0) ? tag_wide[TS-1:0] : '0;

	assign rd_key = rd_data_q[EW-1:TS];
	assign rd_tag = rd_data_q[TS-1:0];

	assign parent  = (idx_q - AW'(1)) >> 1;
	assign left_w  = LW'({idx_q, 1'b1});
	assign right_w = left_w + LW'(1);
	assign count_w = LW'(count_q);

	// operand selection for the shared comparator
	always_comb begin
		cmp_a = x_key_q;
		cmp_b = rd_key;
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = rd_key;
				cmp_b = x_key_q;
			end
			S_DN_R: begin
				cmp_a = best_key_q;
				cmp_b = rd_key;
			end
			default: begin
				cmp_a = x_key_q;
				cmp_b = rd_key;
			end
		endcase
	end

	hpq_rank #(.KEY_WIDTH(KEY_WIDTH)) u_rank (
		.mode  (mode_q),
		.a     (cmp_a),
		.b     (cmp_b),
		.lower (cmp_lower)
	);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = {x_key_q, x_tag_q};
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.opcode == OP_REMOVE && count_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_UP_CHK: begin
				if (idx_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (cmp_lower) begin
					wr_data = rd_data_q;
				end
			end
			S_RM_ROOT: begin
				rd_en   = 1'b1;
				rd_addr = count_q[AW-1:0];
			end
			S_RM_LAST: begin
			end
			S_DN_CHK: begin
				if (left_w >= count_w) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = left_w[AW-1:0];
				end
			end
			S_DN_L: begin
				if (right_w < count_w) begin
					rd_en   = 1'b1;
					rd_addr = right_w[AW-1:0];
				end else begin
					wr_en = 1'b1;
					if (cmp_lower) begin
						wr_data = rd_data_q;
					end
				end
			end
			S_DN_R: begin
				wr_en = 1'b1;
				if (cmp_lower) begin
					wr_data = rd_data_q;
				end else if (best_child_q) begin
					wr_data = {best_key_q, best_tag_q};
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_key_q    <= '0;
						res_tag_q    <= '0;
						res_status_q <= STATUS_OK;
						if (req.opcode == OP_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								res_status_q <= STATUS_FULL;
								state_q      <= S_DONE;
							end else begin
								x_key_q <= key_in;
								x_tag_q <= tag_in;
								idx_q   <= count_q[AW-1:0];
								count_q <= count_q + CW'(1);
								state_q <= S_UP_CHK;
							end
						end else begin
							if (count_q == '0) begin
								res_status_q <= STATUS_EMPTY;
								state_q      <= S_DONE;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_RM_ROOT;
							end
						end
					end
				end
				S_UP_CHK: begin
					state_q <= (idx_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_lower) begin
						idx_q   <= parent;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RM_ROOT: begin
					res_key_q <= rd_key;
					res_tag_q <= rd_tag;
					state_q   <= S_RM_LAST;
				end
				S_RM_LAST: begin
					// last entry becomes the carried entry, hole at the root
					x_key_q <= rd_key;
					x_tag_q <= rd_tag;
					idx_q   <= '0;
					state_q <= S_DN_CHK;
				end
				S_DN_CHK: begin
					state_q <= (left_w >= count_w) ? S_DONE : S_DN_L;
				end
				S_DN_L: begin
					best_child_q <= cmp_lower;
					best_key_q   <= cmp_lower ? rd_key : x_key_q;
					best_tag_q   <= cmp_lower ? rd_tag : x_tag_q;
					if (right_w < count_w) begin
						state_q <= S_DN_R;
					end else if (cmp_lower) begin
						idx_q   <= left_w[AW-1:0];
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DN_R: begin
					if (cmp_lower) begin
						idx_q   <= right_w[AW-1:0];
						state_q <= S_DN_CHK;
					end else if (best_child_q) begin
						idx_q   <= left_w[AW-1:0];
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_key_q    <= res_key_q;
						out_tag_q    <= res_tag_q;
						out_count_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	logic [KEY_WIDTH+PRIO_W-1:0] out_key_wide;
	logic [TS+TAG_W-1:0]         out_tag_wide;
	logic [CW+OCC_W-1:0]         out_count_wide;

	assign out_key_wide   = {{PRIO_W{1'b0}}, out_key_q};
	assign out_tag_wide   = {{TAG_W{1'b0}}, out_tag_q};
	assign out_count_wide = {{OCC_W{1'b0}}, out_count_q};

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.out_priority = out_key_wide[PRIO_W-1:0];
	assign rsp.out_tag      = out_tag_wide[TAG_W-1:0];
	assign rsp.occupancy    = out_count_wide[OCC_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer idle right after a request");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && out_status_q == STATUS_EMPTY |-> out_count_q == '0)
		else $error("empty status with entries held");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && out_status_q != STATUS_OK |-> out_key_q == '0 && out_tag_q == '0)
		else $error("refused request carries an entry");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> out_status_q == STATUS_OK || out_status_q == STATUS_FULL ||
			out_status_q == STATUS_EMPTY)
		else $error("undefined status code");

endmodule
